// ----- design/efrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package efrc_pkg;

	localparam int MAX_FRAME = 64;
	localparam int CNT_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd2;

	localparam logic [7:0] START_RESET  = 8'd1;
	localparam logic [7:0] END_RESET    = 8'd3;
	localparam logic [7:0] ESCAPE_RESET = 8'd16;

	// kind of a received byte as seen by the escape tracker
	typedef enum logic [1:0] {
		KIND_PEND,
		KIND_LIT,
		KIND_PLAIN,
		KIND_ILLEGAL
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       is_start;
		logic       is_end;
		logic [7:0] data;
	} cls_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             data_valid;
		logic             frame_done;
		logic             frame_good;
		logic [CNT_W-1:0] frame_length;
		logic             frame_abort;
	} res_t;

endpackage
`default_nettype wire

// ----- design/efrc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module efrc_front (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [efrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [7:0]                      cfg_data,
	input  wire                            accept,
	input  wire [7:0]                      rx_byte,
	output efrc_pkg::cls_t                 cls
);

	logic [7:0] start_q;
	logic [7:0] end_q;
	logic [7:0] esc_code_q;
	logic       esc_q;
	logic       m_start;
	logic       m_end;
	logic       m_esc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= efrc_pkg::START_RESET;
			end_q      <= efrc_pkg::END_RESET;
			esc_code_q <= efrc_pkg::ESCAPE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				efrc_pkg::REG_START:  start_q    <= cfg_data;
				efrc_pkg::REG_END:    end_q      <= cfg_data;
				efrc_pkg::REG_ESCAPE: esc_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign m_start = (rx_byte == start_q);
	assign m_end   = (rx_byte == end_q);
	assign m_esc   = (rx_byte == esc_code_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
		end else if (accept) begin
			esc_q <= !esc_q && m_esc;
		end
	end

	always_comb begin
		cls.data     = rx_byte;
		cls.is_start = m_start;
		cls.is_end   = m_end;
		if (esc_q) begin
			cls.kind = (m_esc || m_start || m_end) ? efrc_pkg::KIND_LIT
				: efrc_pkg::KIND_ILLEGAL;
		end else if (m_esc) begin
			cls.kind = efrc_pkg::KIND_PEND;
		end else begin
			cls.kind = efrc_pkg::KIND_PLAIN;
		end
	end

endmodule
`default_nettype wire

// ----- design/efrc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module efrc_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            wr_en,
	input  efrc_pkg::cls_t wr_data,
	output logic           full,
	input  wire            rd_en,
	output efrc_pkg::cls_t rd_data,
	output logic           empty
);

	efrc_pkg::cls_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= !wr_ptr_q;
			if (rd_en) rd_ptr_q <= !rd_ptr_q;
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/efrc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module efrc_back (
	input  wire                         clk,
	input  wire                         arst_n,
	input  efrc_pkg::cls_t              cls,
	input  wire                         cls_avail,
	output logic                        cls_take,
	output logic                        empty,
	input  wire                         pop,
	output efrc_pkg::res_t              res
);

	localparam logic [efrc_pkg::CNT_W-1:0] MAX_CNT = efrc_pkg::CNT_W'(efrc_pkg::MAX_FRAME);

	logic                        in_frame_q;
	logic [efrc_pkg::CNT_W-1:0]  cnt_q;
	logic [7:0]                  lo_q;
	logic [7:0]                  hi_q;
	logic [7:0]                  h0_q;
	logic [7:0]                  h1_q;

	logic                        in_frame_n;
	logic [efrc_pkg::CNT_W-1:0]  cnt_n;
	logic [7:0]                  lo_n;
	logic [7:0]                  hi_n;
	logic [7:0]                  h0_n;
	logic [7:0]                  h1_n;
	logic                        do_store;
	logic                        do_abort;
	logic                        do_open;
	logic                        do_close;
	logic                        room;
	logic [7:0]                  lo_acc;
	efrc_pkg::res_t              res_n;

	efrc_pkg::res_t              obuf_q [2];
	logic                        owr_q;
	logic                        ord_q;
	logic [1:0]                  ocnt_q;
	logic                        opop;

	assign room  = (cnt_q < MAX_CNT);
	assign empty = (ocnt_q == 2'd0);
	assign res   = obuf_q[ord_q];
	assign opop  = pop && !empty;
	assign cls_take = cls_avail && (ocnt_q != 2'd2);

	// decide what this word does to the frame
	always_comb begin
		do_store = 1'b0;
		do_abort = 1'b0;
		do_open  = 1'b0;
		do_close = 1'b0;
		case (cls.kind)
			efrc_pkg::KIND_PEND: ;
			efrc_pkg::KIND_LIT: begin
				if (in_frame_q) begin
					do_store = room;
					do_abort = !room;
				end
			end
			efrc_pkg::KIND_PLAIN: begin
				if (!in_frame_q && cls.is_start) begin
					do_open = 1'b1;
				end else if (in_frame_q && cls.is_end) begin
					do_close = 1'b1;
				end else if (in_frame_q && room) begin
					do_store = 1'b1;
				end else begin
					do_abort = 1'b1;
				end
			end
			efrc_pkg::KIND_ILLEGAL: do_abort = 1'b1;
			default: do_abort = 1'b1;
		endcase
	end

	always_comb begin
		in_frame_n = in_frame_q;
		cnt_n      = cnt_q;
		lo_n       = lo_q;
		hi_n       = hi_q;
		h0_n       = h0_q;
		h1_n       = h1_q;
		lo_acc     = lo_q + h0_q;
		if (do_open) begin
			in_frame_n = 1'b1;
			cnt_n      = '0;
			lo_n       = '0;
			hi_n       = '0;
			h0_n       = '0;
			h1_n       = '0;
		end else if (do_close) begin
			in_frame_n = 1'b0;
		end else if (do_abort) begin
			in_frame_n = 1'b0;
			cnt_n      = '0;
		end else if (do_store) begin
			// fold the oldest held byte in once two are waiting
			if (cnt_q >= efrc_pkg::CNT_W'(2)) begin
				lo_n = lo_acc;
				hi_n = hi_q + lo_acc;
			end
			h0_n  = h1_q;
			h1_n  = cls.data;
			cnt_n = cnt_q + efrc_pkg::CNT_W'(1);
		end
	end

	always_comb begin
		res_n.data_byte    = do_store ? cls.data : 8'd0;
		res_n.data_valid   = do_store;
		res_n.frame_done   = do_close;
		res_n.frame_good   = do_close && (cnt_q >= efrc_pkg::CNT_W'(3))
			&& (h0_q == lo_q) && (h1_q == hi_q);
		res_n.frame_length = cnt_n;
		res_n.frame_abort  = do_abort;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cnt_q      <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			h0_q       <= '0;
			h1_q       <= '0;
		end else if (cls_take) begin
			in_frame_q <= in_frame_n;
			cnt_q      <= cnt_n;
			lo_q       <= lo_n;
			hi_q       <= hi_n;
			h0_q       <= h0_n;
			h1_q       <= h1_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cls_take) begin
			obuf_q[owr_q] <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (cls_take) owr_q <= !owr_q;
			if (opop)     ord_q <= !ord_q;
			case ({cls_take, opop})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/escaped_frame_receiver_checksum.sv -----
// A pushed word passes the queue register, then the result buffer, before it can be popped.
// Throughput: one word per cycle when neither side stalls; the two-entry queue behind the escape
// tracker and the two-entry result buffer let both sides stall independently.
// Reset (arst_n low, asynchronous): both queues empty, no frame open, no escape
// pending, codes back to start 1, end 3, escape 16.
`timescale 1ns / 1ps
`default_nettype none
module escaped_frame_receiver_checksum (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [efrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [7:0]                      cfg_data,
	input  wire                            push,
	output logic                           full,
	input  wire [7:0]                      rx_byte,
	output logic                           empty,
	input  wire                            pop,
	output logic [7:0]                     data_byte,
	output logic                           data_valid,
	output logic                           frame_done,
	output logic                           frame_good,
	output logic [efrc_pkg::CNT_W-1:0]     frame_length,
	output logic                           frame_abort
);

	logic           accept;
	logic           q_empty;
	logic           q_take;
	efrc_pkg::cls_t cls_in;
	efrc_pkg::cls_t cls_out;
	efrc_pkg::res_t res;

	assign accept = push && !full;

	efrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.cls       (cls_in)
	);

	efrc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (cls_in),
		.full    (full),
		.rd_en   (q_take),
		.rd_data (cls_out),
		.empty   (q_empty)
	);

	efrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_out),
		.cls_avail (!q_empty),
		.cls_take  (q_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign data_byte    = res.data_byte;
	assign data_valid   = res.data_valid;
	assign frame_done   = res.frame_done;
	assign frame_good   = res.frame_good;
	assign frame_length = res.frame_length;
	assign frame_abort  = res.frame_abort;

endmodule
`default_nettype wire

// ----- design/efrc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module efrc_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            empty,
	input wire                            pop,
	input wire [7:0]                      data_byte,
	input wire                            data_valid,
	input wire                            frame_done,
	input wire                            frame_good,
	input wire [efrc_pkg::CNT_W-1:0]      frame_length,
	input wire                            frame_abort
);

	a_good_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_good) |-> frame_done)
		else $error("frame_good without frame_done");

	a_valid_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && data_valid) |-> (!frame_done && !frame_abort && frame_length != 0))
		else $error("stored word flagged as done, abort or zero length");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (frame_length <= efrc_pkg::CNT_W'(efrc_pkg::MAX_FRAME)))
		else $error("frame_length beyond frame limit");

	a_abort_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_abort) |-> (frame_length == 0 && !frame_good))
		else $error("abort left a length or a good flag");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(frame_length)))
		else $error("waiting word changed before pop");

endmodule

bind escaped_frame_receiver_checksum efrc_checker u_efrc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.data_byte    (data_byte),
	.data_valid   (data_valid),
	.frame_done   (frame_done),
	.frame_good   (frame_good),
	.frame_length (frame_length),
	.frame_abort  (frame_abort)
);
`default_nettype wire

// ----- tb/efrc_result_checker.sv -----
`timescale 1ns / 1ps
module efrc_result_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [efrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [7:0]                     cfg_data,
	input  wire                           push,
	input  wire                           full,
	input  wire [7:0]                     rx_byte,
	input  wire                           empty,
	input  wire                           pop,
	input  wire [7:0]                     data_byte,
	input  wire                           data_valid,
	input  wire                           frame_done,
	input  wire                           frame_good,
	input  wire [efrc_pkg::CNT_W-1:0]     frame_length,
	input  wire                           frame_abort,
	output int                            mismatches,
	output int                            pending_words,
	output int                            words_checked,
	output int                            good_frames,
	output int                            rejected_frames,
	output int                            aborted_frames
);

	logic [7:0]                 start_code;
	logic [7:0]                 end_code;
	logic [7:0]                 escape_code;
	logic                       in_frame;
	logic                       escape_pending;
	logic [efrc_pkg::CNT_W-1:0] stored_count;
	logic [7:0]                 sum_lo;
	logic [7:0]                 sum_hi;
	logic [7:0]                 held [2];

	efrc_pkg::res_t expected_words [$];
	efrc_pkg::res_t want;
	int             mismatch_total;
	int             checked_total;
	int             good_total;
	int             rejected_total;
	int             abort_total;

	function automatic void store_payload_byte(logic [7:0] b);
		// the two newest bytes wait outside the sums: they are the checksum candidates
		if (stored_count >= 2) begin
			sum_lo = sum_lo + held[0];
			sum_hi = sum_hi + sum_lo;
		end
		held[0] = held[1];
		held[1] = b;
		stored_count = stored_count + 1'b1;
	endfunction

	function automatic efrc_pkg::res_t advance_receiver(logic [7:0] c);
		efrc_pkg::res_t r;
		r = '0;
		if (escape_pending) begin
			escape_pending = 1'b0;
			if (c == escape_code || c == end_code || c == start_code) begin
				if (in_frame) begin
					if (stored_count < efrc_pkg::MAX_FRAME) begin
						store_payload_byte(c);
						r.data_byte  = c;
						r.data_valid = 1'b1;
					end else begin
						in_frame      = 1'b0;
						stored_count  = '0;
						r.frame_abort = 1'b1;
					end
				end
			end else begin
				in_frame      = 1'b0;
				stored_count  = '0;
				r.frame_abort = 1'b1;
			end
		end else if (c == escape_code) begin
			escape_pending = 1'b1;
		end else if (!in_frame && c == start_code) begin
			in_frame     = 1'b1;
			stored_count = '0;
			sum_lo       = '0;
			sum_hi       = '0;
			held[0]      = '0;
			held[1]      = '0;
		end else if (in_frame && c == end_code) begin
			in_frame     = 1'b0;
			r.frame_done = 1'b1;
			r.frame_good = stored_count >= 3 && held[0] == sum_lo && held[1] == sum_hi;
		end else if (in_frame && stored_count < efrc_pkg::MAX_FRAME) begin
			store_payload_byte(c);
			r.data_byte  = c;
			r.data_valid = 1'b1;
		end else begin
			in_frame      = 1'b0;
			stored_count  = '0;
			r.frame_abort = 1'b1;
		end
		r.frame_length = stored_count;
		return r;
	endfunction

	function automatic void check_field(string field, int expected, int actual);
		if (expected != actual) begin
			$error("%s: expected %0d, got %0d", field, expected, actual);
			mismatch_total++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code     = efrc_pkg::START_RESET;
			end_code       = efrc_pkg::END_RESET;
			escape_code    = efrc_pkg::ESCAPE_RESET;
			in_frame       = 1'b0;
			escape_pending = 1'b0;
			stored_count   = '0;
			sum_lo         = '0;
			sum_hi         = '0;
			held[0]        = '0;
			held[1]        = '0;
			expected_words.delete();
		end else begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$error("result word popped with no expectation waiting");
					mismatch_total++;
				end else begin
					want = expected_words.pop_front();
					check_field("data_byte", want.data_byte, data_byte);
					check_field("data_valid", want.data_valid, data_valid);
					check_field("frame_done", want.frame_done, frame_done);
					check_field("frame_good", want.frame_good, frame_good);
					check_field("frame_length", want.frame_length, frame_length);
					check_field("frame_abort", want.frame_abort, frame_abort);
					checked_total++;
					if (want.frame_done) begin
						if (want.frame_good)
							good_total++;
						else
							rejected_total++;
					end
					if (want.frame_abort)
						abort_total++;
				end
			end
			if (push && !full)
				expected_words.push_back(advance_receiver(rx_byte));
			if (cfg_we) begin
				case (cfg_index)
					efrc_pkg::REG_START:  start_code  = cfg_data;
					efrc_pkg::REG_END:    end_code    = cfg_data;
					efrc_pkg::REG_ESCAPE: escape_code = cfg_data;
					default: ;
				endcase
			end
		end
		mismatches      <= mismatch_total;
		pending_words   <= expected_words.size();
		words_checked   <= checked_total;
		good_frames     <= good_total;
		rejected_frames <= rejected_total;
		aborted_frames  <= abort_total;
	end

endmodule

// ----- tb/escaped_frame_receiver_checksum_test.sv -----
`timescale 1ns / 1ps
module escaped_frame_receiver_checksum_test;

	localparam logic [efrc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int NUM_SETTINGS = 6;
	localparam int HOLD_CYCLES  = 300;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [efrc_pkg::CFG_IDX_W-1:0] cfg_index = efrc_pkg::REG_START;
	logic [7:0]                     cfg_data  = 8'h00;
	logic                           push      = 1'b0;
	logic [7:0]                     rx_byte   = 8'h00;
	logic                           pop       = 1'b0;

	wire                       full;
	wire                       empty;
	wire [7:0]                 data_byte;
	wire                       data_valid;
	wire                       frame_done;
	wire                       frame_good;
	wire [efrc_pkg::CNT_W-1:0] frame_length;
	wire                       frame_abort;

	int mismatches;
	int pending_words;
	int words_checked;
	int good_frames;
	int rejected_frames;
	int aborted_frames;

	bit         hold_request = 1'b0;
	bit         steady       = 1'b0;
	int         bytes_sent   = 0;
	int         settings_run = 1;
	logic [7:0] cur_start    = efrc_pkg::START_RESET;
	logic [7:0] cur_end      = efrc_pkg::END_RESET;
	logic [7:0] cur_esc      = efrc_pkg::ESCAPE_RESET;

	// default codes: strays, escapes outside a frame, illegal escape, short and good frames
	logic [7:0] opening_bytes [25] = '{
		8'h00, 8'hFF, efrc_pkg::ESCAPE_RESET, efrc_pkg::START_RESET,
		efrc_pkg::ESCAPE_RESET, 8'h41,
		efrc_pkg::START_RESET, efrc_pkg::END_RESET,
		efrc_pkg::START_RESET, 8'h80, 8'h80, 8'h80, efrc_pkg::END_RESET,
		efrc_pkg::START_RESET, efrc_pkg::ESCAPE_RESET, efrc_pkg::ESCAPE_RESET,
		efrc_pkg::ESCAPE_RESET, efrc_pkg::ESCAPE_RESET,
		efrc_pkg::ESCAPE_RESET, efrc_pkg::ESCAPE_RESET, efrc_pkg::END_RESET,
		efrc_pkg::START_RESET, efrc_pkg::START_RESET, 8'h7F, efrc_pkg::END_RESET
	};

	logic [7:0] start_set  [NUM_SETTINGS] =
		'{8'h7E, 8'h00, 8'hFF, 8'hAA, 8'h3C, efrc_pkg::START_RESET};
	logic [7:0] end_set    [NUM_SETTINGS] =
		'{8'h7F, 8'hFF, 8'h00, 8'hAA, 8'h3C, efrc_pkg::END_RESET};
	logic [7:0] escape_set [NUM_SETTINGS] =
		'{8'h7D, 8'h80, 8'h01, 8'h55, 8'h3C, efrc_pkg::ESCAPE_RESET};

	always #1 clk = ~clk;

	escaped_frame_receiver_checksum u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.data_byte    (data_byte),
		.data_valid   (data_valid),
		.frame_done   (frame_done),
		.frame_good   (frame_good),
		.frame_length (frame_length),
		.frame_abort  (frame_abort)
	);

	efrc_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.push            (push),
		.full            (full),
		.rx_byte         (rx_byte),
		.empty           (empty),
		.pop             (pop),
		.data_byte       (data_byte),
		.data_valid      (data_valid),
		.frame_done      (frame_done),
		.frame_good      (frame_good),
		.frame_length    (frame_length),
		.frame_abort     (frame_abort),
		.mismatches      (mismatches),
		.pending_words   (pending_words),
		.words_checked   (words_checked),
		.good_frames     (good_frames),
		.rejected_frames (rejected_frames),
		.aborted_frames  (aborted_frames)
	);

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	// escape anything the receiver would take as a control code
	task automatic send_stored(input logic [7:0] b);
		if (b == cur_esc || b == cur_end || (b == cur_start && $urandom_range(0, 1)))
			send_byte(cur_esc);
		send_byte(b);
	endtask

	task automatic send_frame(input int payload_len, input bit spoil, input bit close);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] b;
		int         bit_pick;
		lo = 8'h00;
		hi = 8'h00;
		send_byte(cur_start);
		for (int i = 0; i < payload_len; i++) begin
			b  = 8'($urandom);
			lo = lo + b;
			hi = hi + lo;
			send_stored(b);
		end
		if (spoil) begin
			bit_pick = $urandom_range(0, 15);
			if (bit_pick < 8)
				lo[bit_pick] = ~lo[bit_pick];
			else
				hi[bit_pick - 8] = ~hi[bit_pick - 8];
		end
		send_stored(lo);
		send_stored(hi);
		if (close)
			send_byte(cur_end);
	endtask

	task automatic run_traffic(input int word_target);
		int         pick;
		logic [7:0] b;
		while (bytes_sent < word_target) begin
			// a frame cannot open when the start code is also the escape code
			pick = $urandom_range(cur_start == cur_esc ? 84 : 0, 99);
			if (pick < 66) begin
				send_frame($urandom_range(0, 20), $urandom_range(0, 7) == 0, 1'b1);
			end else if (pick < 78) begin
				send_frame($urandom_range(58, 66), $urandom_range(0, 3) == 0, 1'b1);
			end else if (pick < 81) begin
				// fill the frame to the limit, then push one escaped byte past it
				send_frame(62, 1'b0, 1'b0);
				send_byte(cur_esc);
				send_byte($urandom_range(0, 1) ? cur_end : cur_esc);
			end else if (pick < 84) begin
				send_frame($urandom_range(0, 10), 1'b0, 1'b0);
			end else if (pick < 90) begin
				send_byte(cur_esc);
				do b = 8'($urandom); while (b == cur_esc || b == cur_end || b == cur_start);
				send_byte(b);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 5))
						0:       send_byte(cur_start);
						1:       send_byte(cur_end);
						2:       send_byte(cur_esc);
						default: send_byte(8'($urandom));
					endcase
				end
			end
		end
	endtask

	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		wait (pending_words == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_codes(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x);
		cfg_we    <= 1'b1;
		cfg_index <= efrc_pkg::REG_START;
		cfg_data  <= s;
		@(posedge clk);
		cfg_index <= efrc_pkg::REG_END;
		cfg_data  <= e;
		@(posedge clk);
		cfg_index <= efrc_pkg::REG_ESCAPE;
		cfg_data  <= x;
		@(posedge clk);
		// unmapped index: must leave every code alone
		cfg_index <= REG_SPARE;
		cfg_data  <= 8'($urandom);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_start = s;
		cur_end   = e;
		cur_esc   = x;
	endtask

	initial begin : result_drain
		int stall;
		wait (arst_n);
		forever begin
			if (hold_request) begin
				stall        = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = steady ? 0 : $urandom_range(0, 15);
			end
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin : stimulus
		int word_target;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_bytes[i])
			send_byte(opening_bytes[i]);
		drain_results();

		word_target = bytes_sent;
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			write_codes(start_set[p], end_set[p], escape_set[p]);
			settings_run++;
			if (p == 1) begin
				// stall the result side while words keep coming, so the input backs up
				steady       = 1'b1;
				hold_request = 1'b1;
				word_target  = bytes_sent + 40;
				run_traffic(word_target);
				steady       = 1'b0;
			end
			steady      = (p == 2);
			word_target = bytes_sent + (cur_start == cur_esc ? 40 : 250);
			run_traffic(word_target);
			steady = 1'b0;
			drain_results();
		end

		$display("Checked %0d result words from %0d bytes under %0d code settings.",
			words_checked, bytes_sent, settings_run);
		$display("Frames closed good: %0d, closed bad: %0d, aborts: %0d.",
			good_frames, rejected_frames, aborted_frames);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
